>>> rtl/core/pcxd_pkg.sv
package pcxd_pkg;

    // Byte stream geometry
    localparam int HDR_LAST   = 127;       // last header byte position
    localparam int MIN_FILE   = 128 + 769; // shortest well-formed file in bytes
    localparam int POS_W      = 10;        // saturating byte position counter
    localparam int RUN_W      = 6;         // run count field
    localparam int LEFT_W     = 33;        // bytes per line times height

    // Header field slots
    localparam int HDR_XMIN   = 0;
    localparam int HDR_YMIN   = 1;
    localparam int HDR_XMAX   = 2;
    localparam int HDR_YMAX   = 3;
    localparam int HDR_BPL    = 4;
    localparam int HDR_FIELDS = 5;
    localparam int BPL_POS    = 66;        // bytes-per-line low byte offset
    localparam int XMIN_POS   = 4;         // first of the four window fields

    // Byte codes
    localparam logic [7:0] SIGNATURE = 8'h0A;
    localparam logic [1:0] RUN_MARK  = 2'b11;   // top bits of a run count byte

    // Status codes
    localparam logic [1:0] STAT_DECODING = 2'd0;
    localparam logic [1:0] STAT_DONE     = 2'd1;
    localparam logic [1:0] STAT_BAD_HDR  = 2'd2;
    localparam logic [1:0] STAT_TRUNC    = 2'd3;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic        pixel_valid;
        logic [15:0] column;
        logic [15:0] row_number;
        logic [1:0]  status;
        logic        last_of_item;
    } t_out;

    // One classified byte: value, how many decoded bytes it expands to, image geometry
    typedef struct packed {
        logic [7:0]       value;
        logic [RUN_W-1:0] count;
        logic [15:0]      width;
        logic [15:0]      bpl;
        logic [1:0]       status;
        logic             clear;
    } t_job;

endpackage

>>> rtl/core/pcxd_queue.sv
module pcxd_queue #(
    parameter int DEPTH = pcxd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcxd_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pcxd_pkg::t_job  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pcxd_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/pcxd_front.sv
module pcxd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcxd_pkg::t_in   i_in_data,
    output logic            o_push,
    output pcxd_pkg::t_job  o_job,
    input  logic            i_full
);

    localparam logic [2:0] ST_HEADER = 3'd0;
    localparam logic [2:0] ST_CALC   = 3'd1;
    localparam logic [2:0] ST_BODY   = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;
    localparam logic [2:0] ST_FAIL   = 3'd4;

    localparam int PW = pcxd_pkg::POS_W;
    localparam int RW = pcxd_pkg::RUN_W;
    localparam int LW = pcxd_pkg::LEFT_W;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_hdr [pcxd_pkg::HDR_FIELDS];
    logic [15:0]   n_hdr [pcxd_pkg::HDR_FIELDS];
    logic          r_sig, n_sig;
    logic          r_run_pend, n_run_pend;
    logic [RW-1:0] r_run_len, n_run_len;
    logic [LW-1:0] r_left, n_left;
    logic [15:0]   r_w, n_w;
    logic [16:0]   r_h, n_h;

    logic          accept;
    logic [7:0]    b;
    logic          eof;
    logic [PW-1:0] pos_next;
    logic [17:0]   w_s, h_s;
    logic          hdr_bad;
    logic [LW-1:0] prod;
    logic [RW-1:0] cnt, eff;
    logic          done_now;
    logic [1:0]    stat;

    assign o_in_ready = (r_state != ST_CALC) && !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign b          = i_in_data.data_byte;
    assign eof        = i_in_data.end_of_file;
    assign pos_next   = (r_pos == '1) ? r_pos : r_pos + 1'b1;

    // Header check: signature, width, height positive and bytes per line covers width
    assign w_s = {2'b00, r_hdr[pcxd_pkg::HDR_XMAX]} - {2'b00, r_hdr[pcxd_pkg::HDR_XMIN]}
                 + 18'd1;
    assign h_s = {2'b00, r_hdr[pcxd_pkg::HDR_YMAX]} - {2'b00, r_hdr[pcxd_pkg::HDR_YMIN]}
                 + 18'd1;
    assign hdr_bad = !r_sig || w_s[17] || (w_s == '0) || h_s[17] || (h_s == '0) ||
                     ($signed({2'b00, r_hdr[pcxd_pkg::HDR_BPL]}) < $signed(w_s));

    // Image size in bytes, taken in the cycle after the header
    assign prod = LW'(r_hdr[pcxd_pkg::HDR_BPL]) * LW'(r_h);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_sig      = r_sig;
        n_run_pend = r_run_pend;
        n_run_len  = r_run_len;
        n_left     = r_left;
        n_w        = r_w;
        n_h        = r_h;
        cnt        = '0;
        eff        = '0;
        done_now   = 1'b0;
        stat       = pcxd_pkg::STAT_DECODING;

        if (accept) begin
            n_pos = pos_next;
            unique case (r_state)
                ST_HEADER: begin
                    if (r_pos == '0) begin
                        n_sig = (b == pcxd_pkg::SIGNATURE);
                    end
                    // window fields, little endian
                    for (int k = 0; k < 4; k++) begin
                        if (r_pos == PW'(pcxd_pkg::XMIN_POS + 2 * k)) begin
                            n_hdr[k][7:0] = b;
                        end
                        if (r_pos == PW'(pcxd_pkg::XMIN_POS + 2 * k + 1)) begin
                            n_hdr[k][15:8] = b;
                        end
                    end
                    if (r_pos == PW'(pcxd_pkg::BPL_POS)) begin
                        n_hdr[pcxd_pkg::HDR_BPL][7:0] = b;
                    end
                    if (r_pos == PW'(pcxd_pkg::BPL_POS + 1)) begin
                        n_hdr[pcxd_pkg::HDR_BPL][15:8] = b;
                    end
                    if (r_pos == PW'(pcxd_pkg::HDR_LAST)) begin
                        n_w     = w_s[15:0];
                        n_h     = h_s[16:0];
                        n_state = hdr_bad ? ST_FAIL : ST_CALC;
                    end
                end
                ST_BODY: begin
                    // classify: data of a pending run, run count byte, or literal
                    if (r_run_pend) begin
                        n_run_pend = 1'b0;
                        cnt        = r_run_len;
                    end else if (b[7:6] == pcxd_pkg::RUN_MARK) begin
                        n_run_pend = 1'b1;
                        n_run_len  = b[RW-1:0];
                    end else begin
                        cnt = RW'(1);
                    end
                    done_now = (cnt != '0) && (LW'(cnt) >= r_left);
                    eff      = done_now ? r_left[RW-1:0] : cnt;
                    n_left   = r_left - LW'(eff);
                    if (done_now) begin
                        n_state = ST_DONE;
                    end
                end
                default: begin
                end
            endcase

            if (n_state == ST_FAIL) begin
                stat = pcxd_pkg::STAT_BAD_HDR;
            end else if (n_state == ST_DONE) begin
                stat = pcxd_pkg::STAT_DONE;
            end

            // end of file: final verdict, then back to the start of a file
            if (eof) begin
                if (n_state != ST_FAIL &&
                    (n_state != ST_DONE || pos_next < PW'(pcxd_pkg::MIN_FILE))) begin
                    stat = pcxd_pkg::STAT_TRUNC;
                end
                n_state    = ST_HEADER;
                n_pos      = '0;
                n_sig      = 1'b0;
                n_run_pend = 1'b0;
                n_run_len  = '0;
                for (int k = 0; k < pcxd_pkg::HDR_FIELDS; k++) begin
                    n_hdr[k] = '0;
                end
            end
        end else if (r_state == ST_CALC) begin
            n_left  = prod;
            n_state = ST_BODY;
        end
    end

    always_comb begin
        o_job.value  = b;
        o_job.count  = eff;
        o_job.width  = r_w;
        o_job.bpl    = r_hdr[pcxd_pkg::HDR_BPL];
        o_job.status = stat;
        o_job.clear  = eof;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HEADER;
            r_pos      <= '0;
            r_sig      <= 1'b0;
            r_run_pend <= 1'b0;
            r_run_len  <= '0;
            for (int k = 0; k < pcxd_pkg::HDR_FIELDS; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_sig      <= n_sig;
            r_run_pend <= n_run_pend;
            r_run_len  <= n_run_len;
            r_hdr      <= n_hdr;
        end
    end

    // Geometry and byte budget
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_w    <= n_w;
        r_h    <= n_h;
    end

endmodule

>>> rtl/core/pcxd_back.sv
module pcxd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pcxd_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pcxd_pkg::t_out  o_out_data
);

    localparam int RW = pcxd_pkg::RUN_W;

    logic           r_busy, n_busy;
    logic [RW-1:0]  r_rem, n_rem;
    logic           r_any, n_any;
    logic [15:0]    r_col, n_col;
    logic [15:0]    r_row, n_row;
    pcxd_pkg::t_job r_job, n_job;
    logic           r_out_valid;
    pcxd_pkg::t_out r_out, n_out;

    logic          ok_out;
    logic          kept, last_iter, later_kept;
    logic [16:0]   col1;
    logic [15:0]   cols_to_wrap;
    logic [RW-1:0] rem_m1;
    logic          emit;

    assign ok_out      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Lookahead: does any later iteration of this run land on a kept column
    assign kept         = (r_col < r_job.width);
    assign last_iter    = (r_rem == RW'(1));
    assign rem_m1       = r_rem - 1'b1;
    assign col1         = {1'b0, r_col} + 17'd1;
    assign cols_to_wrap = r_job.bpl - 16'd1 - r_col;
    assign later_kept   = !last_iter &&
                          ((col1 < {1'b0, r_job.width}) || (16'(rem_m1) > cols_to_wrap));

    always_comb begin
        n_busy = r_busy;
        n_rem  = r_rem;
        n_any  = r_any;
        n_col  = r_col;
        n_row  = r_row;
        n_job  = r_job;
        n_out  = r_out;
        emit   = 1'b0;
        o_pop  = 1'b0;

        if (!r_busy) begin
            if (i_valid) begin
                if (i_job.count == '0) begin
                    // byte without pixels: one empty result
                    if (ok_out) begin
                        o_pop              = 1'b1;
                        emit               = 1'b1;
                        n_out.pixel_value  = '0;
                        n_out.pixel_valid  = 1'b0;
                        n_out.column       = '0;
                        n_out.row_number   = '0;
                        n_out.status       = i_job.status;
                        n_out.last_of_item = 1'b1;
                        if (i_job.clear) begin
                            n_col = '0;
                            n_row = '0;
                        end
                    end
                end else begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_rem  = i_job.count;
                    n_any  = 1'b0;
                    n_busy = 1'b1;
                end
            end
        end else begin
            // one decoded byte per unstalled step; pad columns pass silently
            if (kept || (last_iter && !r_any)) begin
                if (ok_out) begin
                    emit               = 1'b1;
                    n_out.pixel_value  = kept ? r_job.value : '0;
                    n_out.pixel_valid  = kept;
                    n_out.column       = kept ? r_col : '0;
                    n_out.row_number   = kept ? r_row : '0;
                    n_out.status       = r_job.status;
                    n_out.last_of_item = kept ? !later_kept : 1'b1;
                end
            end
            if (ok_out || !(kept || (last_iter && !r_any))) begin
                n_any = r_any || kept;
                n_rem = rem_m1;
                if (col1 >= {1'b0, r_job.bpl}) begin
                    n_col = '0;
                    n_row = r_row + 16'd1;
                end else begin
                    n_col = col1[15:0];
                end
                if (last_iter) begin
                    n_busy = 1'b0;
                    if (r_job.clear) begin
                        n_col = '0;
                        n_row = '0;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_col  <= n_col;
            r_row  <= n_row;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working job and output payload
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_any <= n_any;
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

>>> rtl/core/pcx_rle_image_decoder_unit.sv
// 8-bit single-plane RLE image decoder.
// Input channel (i_in_valid / o_in_ready / i_in_data): one file byte per
// transfer, header first, end_of_file set on the last byte of a file.
// Output channel (o_out_valid / i_out_ready / o_out_data): every input byte
// yields one or more results. A kept pixel gives one result with its value,
// column and row; a byte that yields no pixel gives one empty result. The
// last result of a byte has last_of_item set, and all results of a byte carry
// the status reached after that byte.
// With the back end idle, a byte that yields no pixel passes through the job
// queue and the result register; a decoded byte also passes the back end's
// working job register. A header byte or a run count byte becomes its empty
// result directly; a literal or a run is loaded, then expanded one decoded byte
// per step (pad columns included) by the single expansion step in the back end,
// which takes no new byte until it is through. The input also pauses after the
// header while the image byte budget is multiplied out. A short job queue lets
// the front keep taking bytes while the back end expands a run.
// Reset clears all control state; the block then waits for a header.
// When the receiver holds i_out_ready low, the result register holds, the
// back end stops, the queue fills and o_in_ready drops.
module pcx_rle_image_decoder_unit #(
    parameter int QUEUE_DEPTH = pcxd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pcxd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pcxd_pkg::t_out o_out_data
);

    logic           push, full, pop, q_valid;
    pcxd_pkg::t_job push_job, head_job;

    pcxd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    pcxd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_job)
    );

    pcxd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/pcxd_checker.sv
module pcxd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pcxd_pkg::t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An empty result is always the last one of its byte, all zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pixel_valid |->
            o_out_data.last_of_item && (o_out_data.pixel_value == 8'd0) &&
            (o_out_data.column == 16'd0) && (o_out_data.row_number == 16'd0))
        else $error("empty result malformed");

    // A bad header never comes with a pixel
    a_bad_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == pcxd_pkg::STAT_BAD_HDR) |->
            !o_out_data.pixel_valid)
        else $error("pixel reported with bad header");

endmodule

bind pcx_rle_image_decoder_unit pcxd_checker u_pcxd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int BODY_TARGET    = 170;  // body bytes, directed image included, that the random part runs up to
    localparam int HOLD_AT        = 150;  // result count that starts the long stall
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DONE, PH_FAIL} dec_phase_e;

    // Expected pixel stream: tracks the decoder state and queues the results
    class pcx_scoreboard;
        pcxd_pkg::t_out expect_q [$];
        int unsigned errors;
        int unsigned results;
        int unsigned pixels;
        int unsigned bytes_in;
        int unsigned file_status [4];

        logic [9:0]  byte_pos;
        logic [15:0] hdr [pcxd_pkg::HDR_FIELDS];
        bit          sig_ok;
        bit          run_pend;
        logic [5:0]  run_len;
        logic [15:0] col;
        int          row;
        dec_phase_e  phase;
        logic [1:0]  fail_code;

        function new();
            clear();
        endfunction

        function void clear();
            byte_pos  = '0;
            hdr       = '{default: '0};
            sig_ok    = 1'b0;
            run_pend  = 1'b0;
            run_len   = '0;
            col       = '0;
            row       = 0;
            phase     = PH_HEADER;
            fail_code = pcxd_pkg::STAT_DECODING;
        endfunction

        function int image_width();
            return int'(hdr[pcxd_pkg::HDR_XMAX]) - int'(hdr[pcxd_pkg::HDR_XMIN]) + 1;
        endfunction

        function int image_height();
            return int'(hdr[pcxd_pkg::HDR_YMAX]) - int'(hdr[pcxd_pkg::HDR_YMIN]) + 1;
        endfunction

        // little-endian header fields at fixed offsets
        function void capture(int unsigned pos, logic [7:0] b);
            int          k;
            int unsigned base;
            k = -1;
            base = 0;
            if (pos == 0) sig_ok = (b == pcxd_pkg::SIGNATURE);
            if (pos >= pcxd_pkg::XMIN_POS && pos < pcxd_pkg::XMIN_POS + 8) begin
                k = (pos - pcxd_pkg::XMIN_POS) / 2;
                base = pcxd_pkg::XMIN_POS + 2 * k;
            end else if (pos == pcxd_pkg::BPL_POS || pos == pcxd_pkg::BPL_POS + 1) begin
                k = pcxd_pkg::HDR_BPL;
                base = pcxd_pkg::BPL_POS;
            end
            if (k >= 0) begin
                if (pos == base) hdr[k][7:0] = b;
                else hdr[k][15:8] = b;
            end
        endfunction

        function void note_byte(pcxd_pkg::t_in item);
            int unsigned    pos;
            int unsigned    cnt;
            logic [7:0]     b;
            logic [1:0]     st;
            pcxd_pkg::t_out pix [$];
            pcxd_pkg::t_out o;
            b = item.data_byte;
            pos = byte_pos;
            cnt = 0;
            bytes_in++;
            if (byte_pos != 10'd1023) byte_pos++;

            if (phase == PH_HEADER) begin
                capture(pos, b);
                if (pos == pcxd_pkg::HDR_LAST) begin
                    if (!sig_ok || image_width() <= 0 || image_height() <= 0 ||
                        int'(hdr[pcxd_pkg::HDR_BPL]) < image_width()) begin
                        phase = PH_FAIL;
                        fail_code = pcxd_pkg::STAT_BAD_HDR;
                    end else begin
                        phase = PH_BODY;
                    end
                end
            end else if (phase == PH_BODY) begin
                // count byte arms a run, the next byte is its value
                if (run_pend) begin
                    run_pend = 1'b0;
                    cnt = run_len;
                end else if (b[7:6] == pcxd_pkg::RUN_MARK) begin
                    run_pend = 1'b1;
                    run_len = b[5:0];
                end else begin
                    cnt = 1;
                end
                // expand, dropping pad columns, wrapping rows
                while (cnt > 0 && phase == PH_BODY) begin
                    cnt--;
                    if (int'(col) < image_width()) begin
                        o = '0;
                        o.pixel_value = b;
                        o.pixel_valid = 1'b1;
                        o.column = col;
                        o.row_number = row[15:0];
                        pix.push_back(o);
                    end
                    if (int'(col) + 1 >= int'(hdr[pcxd_pkg::HDR_BPL])) begin
                        col = '0;
                        row++;
                        if (row >= image_height()) phase = PH_DONE;
                    end else begin
                        col++;
                    end
                end
            end

            case (phase)
                PH_FAIL: st = fail_code;
                PH_DONE: st = pcxd_pkg::STAT_DONE;
                default: st = pcxd_pkg::STAT_DECODING;
            endcase

            // end of file: final verdict, then back to the header state
            if (item.end_of_file) begin
                if (phase != PH_FAIL &&
                    (phase != PH_DONE || int'(byte_pos) < pcxd_pkg::MIN_FILE))
                    st = pcxd_pkg::STAT_TRUNC;
                file_status[st]++;
                clear();
            end

            if (pix.size() == 0) begin
                o = '0;
                pix.push_back(o);
            end
            foreach (pix[i]) begin
                pix[i].status = st;
                pix[i].last_of_item = (i == pix.size() - 1);
                expect_q.push_back(pix[i]);
            end
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(pcxd_pkg::t_out got);
            pcxd_pkg::t_out want;
            results++;
            if (got.pixel_valid === 1'b1) pixels++;
            if (expect_q.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            want = expect_q.pop_front();
            check_field("pixel_value", want.pixel_value, got.pixel_value);
            check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
            check_field("column", want.column, got.column);
            check_field("row_number", want.row_number, got.row_number);
            check_field("status", want.status, got.status);
            check_field("last_of_item", want.last_of_item, got.last_of_item);
        endfunction

        function int unsigned pending();
            return expect_q.size();
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    pcxd_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_ready = 1'b0;
    pcxd_pkg::t_out out_data;

    pcx_scoreboard sb;
    logic [7:0]  file_bytes [$];
    int unsigned body_bytes;
    int unsigned files_sent;
    int unsigned quiet_cycles;
    bit          tx_idles = 1'b1;
    bit          rx_idles = 1'b1;
    int unsigned rx_gap;
    int unsigned rx_hold;

    pcx_rle_image_decoder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random gaps after each transfer, one long stall
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            out_ready = 1'b0;
            rx_hold--;
        end else if (rx_gap != 0) begin
            out_ready = 1'b0;
            rx_gap--;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_data);
            if ($urandom_range(0, 39) == 0) rx_idles = !rx_idles;
            rx_gap = rx_idles ? $urandom_range(0, 11) : 0;
            if (sb.results == HOLD_AT) rx_hold = HOLD_CYCLES;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(pcxd_pkg::t_in item);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) tx_idles = !tx_idles;
        gap = tx_idles ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = item;
        do @(posedge i_clk); while (!in_ready);
        sb.note_byte(item);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        pcxd_pkg::t_in item;
        foreach (file_bytes[i]) begin
            item.data_byte = file_bytes[i];
            item.end_of_file = (i == file_bytes.size() - 1);
            send_byte(item);
        end
        files_sent++;
        file_bytes.delete();
    endtask

    function automatic void put_header(logic [7:0] sig, logic [15:0] xmin, logic [15:0] ymin,
                                       logic [15:0] xmax, logic [15:0] ymax,
                                       logic [15:0] bpl);
        logic [7:0] v;
        for (int p = 0; p <= pcxd_pkg::HDR_LAST; p++) begin
            v = 8'($urandom_range(0, 255));
            case (p)
                0:                     v = sig;
                4:                     v = xmin[7:0];
                5:                     v = xmin[15:8];
                6:                     v = ymin[7:0];
                7:                     v = ymin[15:8];
                8:                     v = xmax[7:0];
                9:                     v = xmax[15:8];
                10:                    v = ymax[7:0];
                11:                    v = ymax[15:8];
                pcxd_pkg::BPL_POS:     v = bpl[7:0];
                pcxd_pkg::BPL_POS + 1: v = bpl[15:8];
                default: ;
            endcase
            file_bytes.push_back(v);
        end
    endfunction

    function automatic void put_run(int unsigned cnt, logic [7:0] v);
        file_bytes.push_back({pcxd_pkg::RUN_MARK, 6'(cnt)});
        file_bytes.push_back(v);
    endfunction

    function automatic void put_pad_to(int unsigned len);
        while (file_bytes.size() < len) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Literals and runs until the image is covered or the token cap is hit
    function automatic longint put_image_body(longint goal, int unsigned cap);
        longint      made;
        int unsigned tokens;
        int unsigned cnt;
        int unsigned r;
        int unsigned start;
        made = 0;
        tokens = 0;
        start = file_bytes.size();
        while (made < goal && tokens < cap) begin
            r = $urandom_range(0, 7);
            if (r < 4) begin
                file_bytes.push_back(8'($urandom_range(0, 8'hBF)));
                made++;
            end else begin
                cnt = (r == 4) ? $urandom_range(0, 3) : $urandom_range(0, 63);
                put_run(cnt, 8'($urandom_range(0, 255)));
                made += cnt;
            end
            tokens++;
        end
        body_bytes += file_bytes.size() - start;
        return made;
    endfunction

    task automatic random_file();
        int unsigned kind;
        int unsigned fault;
        int unsigned w, h, bpl;
        int unsigned xmin, ymin, xmax, ymax;
        int unsigned cut;
        longint      goal;
        longint      made;
        logic [7:0]  sig;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // raw noise of up to 300 bytes, which may end before a full header
            repeat ($urandom_range(1, 300)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 24);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 8);
            bpl = w + $urandom_range(0, 3);
            if (bpl > 65535) bpl = 65535;
            xmin = $urandom_range(0, 65536 - w);
            ymin = $urandom_range(0, 65536 - h);
            xmax = xmin + w - 1;
            ymax = ymin + h - 1;
            sig = pcxd_pkg::SIGNATURE;
            fault = (kind == 1) ? $urandom_range(1, 4) : 0;
            case (fault)
                1: sig = pcxd_pkg::SIGNATURE ^ 8'($urandom_range(1, 255));
                2: begin
                    xmin = $urandom_range(1, 65535);
                    xmax = $urandom_range(0, xmin - 1);
                end
                3: begin
                    ymin = $urandom_range(1, 65535);
                    ymax = $urandom_range(0, ymin - 1);
                end
                4: bpl = $urandom_range(0, w - 1);
                default: ;
            endcase
            put_header(sig, xmin, ymin, xmax, ymax, bpl);
            if (fault == 0) begin
                goal = longint'(bpl) * h;
                made = put_image_body(goal, $urandom_range(8, 60));
                if (made >= goal) begin
                    if ($urandom_range(0, 2) == 0)
                        put_pad_to($urandom_range(pcxd_pkg::MIN_FILE - 3, 1100));
                    else repeat ($urandom_range(0, 3))
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        // now and then the file stops inside the header
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, pcxd_pkg::HDR_LAST);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        send_file();
    endtask

    initial begin
        int unsigned rand_files;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        rx_gap = 0;
        rx_hold = 0;
        quiet_cycles = 0;
        body_bytes = 0;
        files_sent = 0;
        rand_files = 0;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // file that ends on its first byte
        file_bytes.push_back(pcxd_pkg::SIGNATURE);
        send_file();

        // broken headers: signature, negative width, empty height, short lines
        put_header(8'h0B, 0, 0, 3, 1, 4);
        repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file();
        put_header(pcxd_pkg::SIGNATURE, 5, 0, 3, 1, 4);
        file_bytes.push_back(8'h11);
        send_file();
        put_header(pcxd_pkg::SIGNATURE, 0, 10, 3, 9, 4);
        file_bytes.push_back(8'h22);
        send_file();
        put_header(pcxd_pkg::SIGNATURE, 0, 0, 7, 1, 6);
        file_bytes.push_back(8'hC3);
        send_file();

        // 3x3 image, two pad columns: literals, zero run, runs across rows,
        // a run past completion and bytes after it; short file at the end
        put_header(pcxd_pkg::SIGNATURE, 2, 1, 4, 3, 5);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hBF);
        put_run(0, 8'h55);
        put_run(7, 8'hFF);
        put_run(1, 8'hC0);
        put_run(63, 8'h12);
        file_bytes.push_back(8'h33);
        file_bytes.push_back(8'hC5);
        send_file();

        // widest window, file ends right after a run count
        put_header(pcxd_pkg::SIGNATURE, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        put_run(63, 8'h80);
        file_bytes.push_back(8'h3C);
        file_bytes.push_back(8'hC4);
        send_file();

        // one-column image at the top corner of the coordinate space
        put_header(pcxd_pkg::SIGNATURE, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0001);
        put_run(2, 8'h99);
        file_bytes.push_back(8'h01);
        send_file();

        // complete images around the minimum file length, and past saturation
        put_header(pcxd_pkg::SIGNATURE, 0, 0, 3, 1, 4);
        put_run(8, 8'hAA);
        put_pad_to(pcxd_pkg::MIN_FILE - 1);
        send_file();
        put_header(pcxd_pkg::SIGNATURE, 0, 0, 3, 1, 4);
        put_run(8, 8'hAB);
        put_pad_to(pcxd_pkg::MIN_FILE);
        send_file();
        put_header(pcxd_pkg::SIGNATURE, 0, 0, 19, 19, 22);
        void'(put_image_body(22 * 20, 1000));
        put_pad_to(1100);
        send_file();

        // random files
        while (rand_files < 4 || body_bytes < BODY_TARGET) begin
            random_file();
            rand_files++;
        end
        in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d files: %0d complete, %0d bad header, %0d truncated or short",
                 files_sent, sb.file_status[pcxd_pkg::STAT_DONE],
                 sb.file_status[pcxd_pkg::STAT_BAD_HDR],
                 sb.file_status[pcxd_pkg::STAT_TRUNC]);
        $display("%0d bytes in, %0d results checked (%0d pixels), %0d mismatches",
                 sb.bytes_in, sb.results, sb.pixels, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pcxd_pkg.sv
rtl/core/pcxd_queue.sv
rtl/core/pcxd_front.sv
rtl/core/pcxd_back.sv
rtl/core/pcx_rle_image_decoder_unit.sv
rtl/core/pcxd_checker.sv
dv/tb_top.sv
